@@ design/szt_pkg.sv @@
// ----------------------------------------------------------------------------
// szt_pkg: shared definitions for the subset-sum zeta transform block
// Command codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package szt_pkg;

  // Default store geometry
  localparam int unsigned SZT_MAX_LOG_SIZE = 10;
  localparam int unsigned SZT_DATA_WIDTH   = 32;

  // Port widths fixed by the interface
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // Register reset values
  localparam logic [3:0] LOG_SIZE_RST  = 4'd10;
  localparam logic       DIRECTION_RST = 1'b0;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_XFORM = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_SIZE  = 2'd0,
    REG_DIRECTION = 2'd1
  } cfg_reg_t;

endpackage

@@ design/szt_ram.sv @@
// ----------------------------------------------------------------------------
// szt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module szt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/szt_engine.sv @@
// ----------------------------------------------------------------------------
// szt_engine: in-place zeta transform sequencer
// Walks every bit level and every index pair, reading both words through
// the RAM read port and writing the sum back with one shared adder.
// ----------------------------------------------------------------------------
module szt_engine
  import szt_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = SZT_MAX_LOG_SIZE,
  parameter int unsigned DATA_WIDTH   = SZT_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [$clog2(MAX_LOG_SIZE+1)-1:0]   log_size,
  input  logic                                direction,
  output logic                                busy,
  output logic [MAX_LOG_SIZE-1:0]             raddr,
  input  logic [DATA_WIDTH-1:0]               rdata,
  output logic                                we,
  output logic [MAX_LOG_SIZE-1:0]             waddr,
  output logic [DATA_WIDTH-1:0]               wdata
);

  localparam int unsigned AW  = MAX_LOG_SIZE;
  localparam int unsigned LGW = $clog2(MAX_LOG_SIZE+1);

  typedef enum logic [1:0] {
    E_IDLE,
    E_RD_T,
    E_RD_P,
    E_WR
  } eng_state_t;

  eng_state_t            state_r, state_nxt;
  logic [LGW-1:0]        lg_r, lg_nxt;
  logic                  dir_r, dir_nxt;
  logic [LGW-1:0]        bit_r, bit_nxt;
  logic [AW-1:0]         pair_r, pair_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;

  logic [AW-1:0] bsel, bmask, base, target, partner, half_m1;
  logic          last_pair, last_level;

  // Spread the pair counter around the current bit position
  always_comb begin
    bsel    = AW'(1) << bit_r;
    bmask   = bsel - AW'(1);
    base    = ((pair_r & ~bmask) << 1) | (pair_r & bmask);
    target  = base | (dir_r ? bsel : '0);
    partner = base | (dir_r ? '0 : bsel);
    half_m1 = (AW'(1) << (lg_r - LGW'(1))) - AW'(1);
    last_pair  = (pair_r == half_m1);
    last_level = (bit_r == lg_r - LGW'(1));
  end

  // Sequencer: read target, read partner, write sum
  always_comb begin
    state_nxt = state_r;
    lg_nxt    = lg_r;
    dir_nxt   = dir_r;
    bit_nxt   = bit_r;
    pair_nxt  = pair_r;
    acc_nxt   = acc_r;
    raddr     = target;
    we        = 1'b0;
    case (state_r)
      E_IDLE: begin
        if (start && (log_size != '0)) begin
          state_nxt = E_RD_T;
          lg_nxt    = log_size;
          dir_nxt   = direction;
          bit_nxt   = '0;
          pair_nxt  = '0;
        end
      end
      E_RD_T: begin
        state_nxt = E_RD_P;
      end
      E_RD_P: begin
        raddr     = partner;
        acc_nxt   = rdata;
        state_nxt = E_WR;
      end
      E_WR: begin
        we = 1'b1;
        if (!last_pair) begin
          pair_nxt  = pair_r + AW'(1);
          state_nxt = E_RD_T;
        end else if (!last_level) begin
          pair_nxt  = '0;
          bit_nxt   = bit_r + LGW'(1);
          state_nxt = E_RD_T;
        end else begin
          state_nxt = E_IDLE;
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  assign waddr = target;
  assign wdata = acc_r + rdata;
  assign busy  = (state_r != E_IDLE);

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lg_r   <= lg_nxt;
    dir_r  <= dir_nxt;
    bit_r  <= bit_nxt;
    pair_r <= pair_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

@@ design/subset_sum_zeta_transform_top.sv @@
// ----------------------------------------------------------------------------
// subset_sum_zeta_transform_top: subset-sum zeta transform block
// Holds a word array and runs superset or subset sum transforms in place.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries command, index and value.
//   A write stores a word. A read returns the word on the out_ channel
//   through the RAM read register and the result register; a read waits
//   while the result register is full and stalled or a read is still
//   in flight. A transform holds in_stall high until it ends: each index
//   pair takes two RAM reads and one write through the single read port
//   and the shared adder. Otherwise writes transfer every cycle.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets
//   log_size (index 0) and direction (index 1); cfg_ready is low during a
//   transform. A log_size above MAX_LOG_SIZE is taken as MAX_LOG_SIZE.
//   Reset sets log_size to 10, direction to superset sums and empties the
//   result register; array contents are undefined until written.
//   When out_stall is high the result holds in out_read_value.
// ----------------------------------------------------------------------------
module subset_sum_zeta_transform_top
  import szt_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = SZT_MAX_LOG_SIZE,
  parameter int unsigned DATA_WIDTH   = SZT_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [INDEX_W-1:0]    in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [VALUE_W-1:0] out_read_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW    = MAX_LOG_SIZE;
  localparam int unsigned LGW   = $clog2(MAX_LOG_SIZE+1);
  localparam int unsigned DEPTH = 1 << MAX_LOG_SIZE;

  logic [3:0]            log_size_r;
  logic                  direction_r;
  logic                  rd_pend_r;
  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_data_r;

  cmd_t                  cmd;
  logic                  in_xfer, is_read;
  logic                  wr_cmd, rd_cmd, xf_cmd;
  logic [LGW-1:0]        lg_sat;
  logic [AW+INDEX_W-1:0] idx_ext;
  logic [AW-1:0]         idx;
  logic [DATA_WIDTH+VALUE_W-1:0] val_ext, rd_ext;

  logic                  eng_busy, eng_we;
  logic [AW-1:0]         eng_raddr, eng_waddr;
  logic [DATA_WIDTH-1:0] eng_wdata;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // Decode the incoming command
  assign cmd     = cmd_t'(in_command);
  assign is_read = (cmd == CMD_READ);
  assign in_stall = eng_busy | (is_read & (rd_pend_r | (out_valid_r & out_stall)));
  assign in_xfer = in_valid & ~in_stall;
  assign wr_cmd  = in_xfer & (cmd == CMD_WRITE);
  assign rd_cmd  = in_xfer & is_read;
  assign xf_cmd  = in_xfer & (cmd == CMD_XFORM);

  // Fit index and value to the store geometry
  assign idx_ext = {{AW{1'b0}}, in_index};
  assign idx     = idx_ext[AW-1:0];
  assign val_ext = {{DATA_WIDTH{1'b0}}, in_value};
  assign rd_ext  = {{VALUE_W{1'b0}}, ram_rdata};

  // Clamp the active size to the store
  assign lg_sat = (32'(log_size_r) > MAX_LOG_SIZE) ? LGW'(MAX_LOG_SIZE)
                                                   : LGW'(log_size_r);

  // Configuration writes
  assign cfg_ready = ~eng_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_size_r  <= LOG_SIZE_RST;
      direction_r <= DIRECTION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOG_SIZE:  log_size_r  <= cfg_data;
        REG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  szt_engine #(
    .MAX_LOG_SIZE (MAX_LOG_SIZE),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (xf_cmd),
    .log_size  (lg_sat),
    .direction (direction_r),
    .busy      (eng_busy),
    .raddr     (eng_raddr),
    .rdata     (ram_rdata),
    .we        (eng_we),
    .waddr     (eng_waddr),
    .wdata     (eng_wdata)
  );

  // Share the RAM ports between host commands and the engine
  assign ram_we    = eng_we | wr_cmd;
  assign ram_waddr = eng_busy ? eng_waddr : idx;
  assign ram_wdata = eng_busy ? eng_wdata : val_ext[DATA_WIDTH-1:0];
  assign ram_raddr = eng_busy ? eng_raddr : idx;

  szt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: load read data, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_cmd;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (rd_pend_r) begin
      out_data_r <= rd_ext[VALUE_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

endmodule
